/* rtl/tib_pkg.sv */
// Shared types and constants for the timestamp interval bucketer.
// Holds the bar mode codes, the calendar date struct and the month length lookup.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package tib_pkg;

    // Bar mode codes as held in the configuration register
    typedef enum logic [3:0] {
        MODE_1MIN  = 4'd0,
        MODE_5MIN  = 4'd1,
        MODE_10MIN = 4'd2,
        MODE_15MIN = 4'd3,
        MODE_30MIN = 4'd4,
        MODE_HOUR  = 4'd5,
        MODE_DAY   = 4'd6,
        MODE_WEEK  = 4'd7,
        MODE_MONTH = 4'd8
    } bucket_mode_t;

    // Calendar date, as produced by the week end block
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // Days in a month; months outside 1..12 give zero
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                        len = leap ? 5'd29 : 5'd28;
                default:                                     len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/tib_week_end.sv */
// Sunday end-of-week date for a given date and weekday.
// Steps forward up to six days with month and year rollover.
// Depends on tib_pkg (date_t).
`timescale 1ns / 1ps
`default_nettype none

module tib_week_end (
    input  wire logic [13:0]   year,
    input  wire logic [3:0]    month,
    input  wire logic [4:0]    day,
    input  wire logic [4:0]    mlen,   // length of the current month
    input  wire logic [2:0]    dow,    // 0 = Sunday .. 6 = Saturday
    output tib_pkg::date_t     end_date
);
    import tib_pkg::*;

    logic [2:0] days_left;
    logic [5:0] day_sum;
    logic       wrap;
    logic       dec;

    // Count days up to the coming Sunday
    always_comb
    begin
        days_left = (dow == 3'd0) ? 3'd0 : 3'(3'd7 - dow);
        day_sum   = 6'(day) + 6'(days_left);
        wrap      = (day_sum > 6'(mlen));
        dec       = (month == 4'd12);
    end

    // Roll into the next month, and the next year after December
    always_comb
    begin
        end_date.year  = year;
        end_date.month = month;
        end_date.day   = day_sum[4:0];
        if (wrap)
        begin
            end_date.day   = 5'(day_sum - 6'(mlen));
            end_date.month = dec ? 4'd1 : 4'(month + 4'd1);
            end_date.year  = dec ? 14'(year + 14'd1) : year;
        end
    end

endmodule

`default_nettype wire

/* rtl/timestamp_interval_bucketer_unit.sv */
// Timestamp interval bucketer, top level: stream ports, mode register, pipeline.
// Maps a calendar timestamp to the last second of its bar interval.
// Depends on tib_pkg and tib_week_end.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, one timestamp per beat.
//   Results leave on m_tvalid/m_tready/m_tdata with m_tuser as the date-valid
//   flag; an invalid date or unused mode gives m_tuser = 0 and zero data.
//   The bar mode is written on cfg_valid/cfg_ready/cfg_data while idle;
//   cfg_ready is always high and the mode is sampled when a beat is taken.
// Pipeline:
//   An input beat passes through three register stages (range checks and
//   divide-by-100, leap year and weekday sum, mod-7 and day check) and then
//   the output register. Throughput is one beat per cycle while m_tready
//   is high; each stage holds its own valid bit.
// Reset and stalls:
//   rst_n clears all valid bits and sets the mode to one-minute bars.
//   When m_tready is low the output beat holds; empty stages upstream keep
//   filling, and s_tready drops only when every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_interval_bucketer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // in_year[13:0], in_month[17:14], in_day[22:18], in_hour[27:23],
    // in_minute[33:28], in_second[39:34]
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // end_year[13:0], end_month[17:14], end_day[22:18], end_hour[27:23],
    // end_minute[33:28], end_second[39:34]
    output logic [39:0]      m_tdata,
    // date_valid[0]
    output logic             m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // bucket_mode[3:0]
    input  wire logic [3:0]  cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import tib_pkg::*;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  min_end;
        logic [13:0] yy;
        logic [7:0]  y_q100;
        logic [7:0]  yy_q100;
        logic [3:0]  mode;
        logic        ok;
    } st1_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  min_end;
        logic [4:0]  mlen;
        logic [14:0] dow_sum;
        logic [3:0]  mode;
        logic        ok;
    } st2_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  min_end;
        logic [4:0]  mlen;
        logic [2:0]  dow;
        logic [3:0]  mode;
        logic        ok;
    } st3_t;

    // Mod 7 by octal digit folding (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [14:0] x);
        logic [5:0] s;
        logic [3:0] t;
        begin
            s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
            t = 4'(s[2:0]) + 4'(s[5:3]);
            return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
        end
    endfunction

    // Weekday offset per month for the Sunday-based weekday sum
    function automatic logic [2:0] month_offset(input logic [3:0] month);
        logic [2:0] off;
        begin
            case (month)
                4'd1:    off = 3'd0;
                4'd2:    off = 3'd3;
                4'd3:    off = 3'd2;
                4'd4:    off = 3'd5;
                4'd5:    off = 3'd0;
                4'd6:    off = 3'd3;
                4'd7:    off = 3'd5;
                4'd8:    off = 3'd1;
                4'd9:    off = 3'd4;
                4'd10:   off = 3'd6;
                4'd11:   off = 3'd2;
                4'd12:   off = 3'd4;
                default: off = 3'd0;
            endcase
            return off;
        end
    endfunction

    logic [3:0]  mode_reg;
    logic        st1_v_reg, st2_v_reg, st3_v_reg, out_v_reg;
    st1_t        st1_reg, st1_next;
    st2_t        st2_reg, st2_next;
    st3_t        st3_reg, st3_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        out_user_reg, out_user_next;
    logic        out_load, st3_load, st2_load, st1_load;

    // Input field views
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;

    assign in_year   = s_tdata[13:0];
    assign in_month  = s_tdata[17:14];
    assign in_day    = s_tdata[22:18];
    assign in_hour   = s_tdata[27:23];
    assign in_minute = s_tdata[33:28];
    assign in_second = s_tdata[39:34];

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_1MIN;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    // Stage advance: a stage loads when empty or when its successor loads
    always_comb
    begin
        out_load = !out_v_reg || m_tready;
        st3_load = !st3_v_reg || out_load;
        st2_load = !st2_v_reg || st3_load;
        st1_load = !st1_v_reg || st2_load;
    end

    assign s_tready = st1_load;

    // Stage 1: range checks, bar minute end, divide years by 100
    logic [13:0] yy1;
    logic [26:0] y_prod, yy_prod;
    logic [9:0]  q5_prod;
    logic [3:0]  q5;

    always_comb
    begin
        yy1     = (in_month <= 4'd2) ? 14'(in_year - 14'd1) : in_year;
        y_prod  = 27'(in_year) * 27'd5243;
        yy_prod = 27'(yy1) * 27'd5243;
        q5_prod = 10'(in_minute) * 10'd13;
        q5      = q5_prod[9:6];

        st1_next.year    = in_year;
        st1_next.month   = in_month;
        st1_next.day     = in_day;
        st1_next.hour    = in_hour;
        st1_next.yy      = yy1;
        st1_next.y_q100  = y_prod[26:19];
        st1_next.yy_q100 = yy_prod[26:19];
        st1_next.mode    = mode_reg;
        st1_next.ok      = (in_year >= 14'd1) && (in_year <= 14'd9998) &&
                           (in_month >= 4'd1) && (in_month <= 4'd12) &&
                           (in_hour <= 5'd23) && (in_minute <= 6'd59) &&
                           (in_second <= 6'd59) && (mode_reg <= MODE_MONTH);

        case (mode_reg)
            MODE_1MIN:  st1_next.min_end = in_minute;
            MODE_5MIN:  st1_next.min_end = 6'({q5, 2'b00} + 6'(q5) + 6'd4);
            MODE_10MIN:
            begin
                if (in_minute < 6'd10)      st1_next.min_end = 6'd9;
                else if (in_minute < 6'd20) st1_next.min_end = 6'd19;
                else if (in_minute < 6'd30) st1_next.min_end = 6'd29;
                else if (in_minute < 6'd40) st1_next.min_end = 6'd39;
                else if (in_minute < 6'd50) st1_next.min_end = 6'd49;
                else                        st1_next.min_end = 6'd59;
            end
            MODE_15MIN:
            begin
                if (in_minute < 6'd15)      st1_next.min_end = 6'd14;
                else if (in_minute < 6'd30) st1_next.min_end = 6'd29;
                else if (in_minute < 6'd45) st1_next.min_end = 6'd44;
                else                        st1_next.min_end = 6'd59;
            end
            MODE_30MIN: st1_next.min_end = (in_minute < 6'd30) ? 6'd29 : 6'd59;
            default:    st1_next.min_end = 6'd59;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st1_v_reg <= 1'b0;
        else if (st1_load)
            st1_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (st1_load)
            st1_reg <= st1_next;
    end

    // Stage 2: leap year, month length, weekday sum
    logic [13:0] r100;
    logic        leap;

    always_comb
    begin
        r100 = 14'(st1_reg.year - 14'({st1_reg.y_q100, 6'b0} +
                                      {st1_reg.y_q100, 5'b0} +
                                      {st1_reg.y_q100, 2'b0}));
        leap = ((st1_reg.year[1:0] == 2'd0) && (r100 != 14'd0)) ||
               ((r100 == 14'd0) && (st1_reg.y_q100[1:0] == 2'd0));

        st2_next.year    = st1_reg.year;
        st2_next.month   = st1_reg.month;
        st2_next.day     = st1_reg.day;
        st2_next.hour    = st1_reg.hour;
        st2_next.min_end = st1_reg.min_end;
        st2_next.mode    = st1_reg.mode;
        st2_next.ok      = st1_reg.ok;
        st2_next.mlen    = month_len(st1_reg.month, leap);
        st2_next.dow_sum = 15'(15'(st1_reg.yy) + 15'(st1_reg.yy[13:2]) +
                               15'(st1_reg.yy_q100[7:2]) +
                               15'(month_offset(st1_reg.month)) +
                               15'(st1_reg.day) - 15'(st1_reg.yy_q100));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st2_v_reg <= 1'b0;
        else if (st2_load)
            st2_v_reg <= st1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (st2_load)
            st2_reg <= st2_next;
    end

    // Stage 3: weekday and day-of-month check
    always_comb
    begin
        st3_next.year    = st2_reg.year;
        st3_next.month   = st2_reg.month;
        st3_next.day     = st2_reg.day;
        st3_next.hour    = st2_reg.hour;
        st3_next.min_end = st2_reg.min_end;
        st3_next.mlen    = st2_reg.mlen;
        st3_next.mode    = st2_reg.mode;
        st3_next.dow     = mod7(st2_reg.dow_sum);
        st3_next.ok      = st2_reg.ok && (st2_reg.day != 5'd0) &&
                           (st2_reg.day <= st2_reg.mlen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st3_v_reg <= 1'b0;
        else if (st3_load)
            st3_v_reg <= st2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (st3_load)
            st3_reg <= st3_next;
    end

    // Stage 4: week end date and final select into the output register
    date_t week_date;

    tib_week_end u_week_end (
        .year     (st3_reg.year),
        .month    (st3_reg.month),
        .day      (st3_reg.day),
        .mlen     (st3_reg.mlen),
        .dow      (st3_reg.dow),
        .end_date (week_date)
    );

    logic [13:0] ey;
    logic [3:0]  em;
    logic [4:0]  ed;
    logic [4:0]  eh;
    logic [5:0]  emi;

    always_comb
    begin
        ey  = st3_reg.year;
        em  = st3_reg.month;
        ed  = st3_reg.day;
        eh  = 5'd23;
        emi = 6'd59;
        case (st3_reg.mode)
            MODE_1MIN, MODE_5MIN, MODE_10MIN, MODE_15MIN, MODE_30MIN, MODE_HOUR:
            begin
                eh  = st3_reg.hour;
                emi = st3_reg.min_end;
            end
            MODE_WEEK:
            begin
                ey = week_date.year;
                em = week_date.month;
                ed = week_date.day;
            end
            MODE_MONTH: ed = st3_reg.mlen;
            default:    ed = st3_reg.day;
        endcase

        out_user_next = st3_reg.ok;
        out_data_next = st3_reg.ok ? {6'd59, emi, eh, ed, em, ey} : 40'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_load)
            out_v_reg <= st3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // An empty output register means the whole pipe can take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output register");

    // Invalid results carry all-zero data
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("invalid result with nonzero data");

    // Valid results end on second 59 with a real month and day
    a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> ((m_tdata[39:34] == 6'd59) &&
                                   (m_tdata[17:14] >= 4'd1) &&
                                   (m_tdata[17:14] <= 4'd12) &&
                                   (m_tdata[22:18] != 5'd0)))
        else $error("valid result with malformed end fields");

    // A beat in stage three moves out once the output register drains
    a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (st3_v_reg && !m_tvalid) |=> m_tvalid)
        else $error("stage three beat did not reach the output register");
`endif

endmodule

`default_nettype wire
